@@ hw/rtl/sbce_pkg.sv @@
// shared types, constants and helpers of the 16-bit cpu execute unit
// no dependencies
`default_nettype none
package sbce_pkg;

    localparam int MEM_BYTES_DEF = 65536;
    localparam int CFG_IDX_W     = 1;
    localparam int S_TDATA_W     = 40;
    localparam int M_TDATA_W     = 88;

    // request kinds, equal to the input opcode values
    localparam logic [1:0] KIND_EXEC = 2'd0;
    localparam logic [1:0] KIND_INTR = 2'd1;
    localparam logic [1:0] KIND_LOAD = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_PC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SSP      = 1'b1;

    localparam logic [3:0] OP_BR   = 4'h0;
    localparam logic [3:0] OP_ADD  = 4'h1;
    localparam logic [3:0] OP_LDB  = 4'h2;
    localparam logic [3:0] OP_STB  = 4'h3;
    localparam logic [3:0] OP_JSR  = 4'h4;
    localparam logic [3:0] OP_AND  = 4'h5;
    localparam logic [3:0] OP_LDR  = 4'h6;
    localparam logic [3:0] OP_STR  = 4'h7;
    localparam logic [3:0] OP_RTI  = 4'h8;
    localparam logic [3:0] OP_NOT  = 4'h9;
    localparam logic [3:0] OP_MUL  = 4'hA;
    localparam logic [3:0] OP_DIV  = 4'hB;
    localparam logic [3:0] OP_JMP  = 4'hC;
    localparam logic [3:0] OP_SHF  = 4'hD;
    localparam logic [3:0] OP_LEA  = 4'hE;
    localparam logic [3:0] OP_TRAP = 4'hF;

    localparam logic [7:0] TRAP_HALT = 8'h25;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] load_address;
        logic [7:0]  load_data;
        logic [7:0]  interrupt_vector;
        logic [2:0]  interrupt_level;
    } item_t;

    // first field in the highest bits
    typedef struct packed {
        logic        fault;
        logic        halted;
        logic        store_is_word;
        logic [15:0] store_value;
        logic [15:0] store_address;
        logic        store_valid;
        logic [15:0] writeback_value;
        logic [2:0]  writeback_index;
        logic        writeback_valid;
        logic [15:0] status_word;
        logic [15:0] next_pc;
    } result_t;

    function automatic logic [2:0] nzp(input logic [15:0] v);
        logic [2:0] f;
        if (v == 16'h0000) begin
            f = 3'b010;
        end else if (v[15]) begin
            f = 3'b100;
        end else begin
            f = 3'b001;
        end
        return f;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sbce_front.sv @@
// front end: takes input requests, classifies them, feeds the queue
// depends on sbce_pkg
`default_nettype none
module sbce_front
    import sbce_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [1:0]           s_tuser,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      push,
    output item_t                     push_item,
    input  wire logic                 q_full
);
    logic  ent_vld_reg;
    item_t ent_reg;
    item_t cls;

    always_comb begin
        cls.kind             = (s_tuser == KIND_NONE) ? KIND_NONE : s_tuser;
        cls.load_address     = s_tdata[15:0];
        cls.load_data        = s_tdata[23:16];
        cls.interrupt_vector = s_tdata[31:24];
        cls.interrupt_level  = s_tdata[34:32];
    end

    assign push      = ent_vld_reg && !q_full;
    assign push_item = ent_reg;
    assign s_tready  = !ent_vld_reg || !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_vld_reg <= 1'b0;
        end else if (s_tready) begin
            ent_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            ent_reg <= cls;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/sbce_queue.sv @@
// two-entry request queue between front and back end
// depends on sbce_pkg
`default_nettype none
module sbce_queue
    import sbce_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  item_t      push_item,
    output logic       full,
    output logic       q_valid,
    output item_t      q_item,
    input  wire logic  pop
);
    item_t      ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = ent_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/sbce_back.sv @@
// back end: sequencer, register file, byte memory, divider, result register
// depends on sbce_pkg
`default_nettype none
module sbce_back
    import sbce_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    input  item_t                     q_item,
    output logic                      pop,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [15:0]          cfg_val,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output result_t                   res
);
    localparam int AW = $clog2(MEM_BYTES);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_FH   = 5'd1;
    localparam logic [4:0] S_FL   = 5'd2;
    localparam logic [4:0] S_DEC  = 5'd3;
    localparam logic [4:0] S_LDB  = 5'd4;
    localparam logic [4:0] S_MUL  = 5'd5;
    localparam logic [4:0] S_DIV  = 5'd6;
    localparam logic [4:0] S_W1   = 5'd7;
    localparam logic [4:0] S_W2   = 5'd8;
    localparam logic [4:0] S_ST2  = 5'd9;
    localparam logic [4:0] S_I1   = 5'd10;
    localparam logic [4:0] S_I2   = 5'd11;
    localparam logic [4:0] S_I3   = 5'd12;
    localparam logic [4:0] S_I4   = 5'd13;
    localparam logic [4:0] S_I5   = 5'd14;
    localparam logic [4:0] S_DONE = 5'd15;

    localparam logic [1:0] WT_LDR     = 2'd0;
    localparam logic [1:0] WT_TRAP    = 2'd1;
    localparam logic [1:0] WT_RTI_PC  = 2'd2;
    localparam logic [1:0] WT_RTI_PSR = 2'd3;

    logic [7:0]  mem [MEM_BYTES];
    logic [7:0]  mem_q;
    logic [15:0] mem_raddr;
    logic [15:0] mem_waddr;
    logic [7:0]  mem_wdata;
    logic        mem_we;

    logic [4:0]  state_reg;
    logic [15:0] gr_reg [8];
    logic [15:0] pc_reg;
    logic [15:0] psr_reg;
    logic [15:0] ssp_reg;
    logic        halt_reg;
    logic        fault_reg;
    item_t       item_reg;
    logic [15:0] inst_reg;
    logic [7:0]  hi_reg;
    logic [15:0] addr_reg;
    logic [15:0] tmp_reg;
    logic [1:0]  wt_reg;
    logic [15:0] prod_reg;
    logic [15:0] div_rem_reg;
    logic [15:0] div_quo_reg;
    logic [15:0] div_d_reg;
    logic [3:0]  div_cnt_reg;
    logic        wb_vld_reg;
    logic [2:0]  wb_idx_reg;
    logic [15:0] wb_val_reg;
    logic        st_vld_reg;
    logic [15:0] st_addr_reg;
    logic [15:0] st_val_reg;
    logic        st_word_reg;
    logic        res_vld_reg;
    result_t     res_reg;

    logic [3:0]  opc;
    logic [2:0]  r1;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] npc;
    logic [15:0] sext6;
    logic [15:0] off9x2;
    logic [15:0] off11x2;
    logic [15:0] ldb_addr;
    logic [15:0] w_addr;
    logic [15:0] shf_val;
    logic [16:0] rem_sh;
    logic        div_ge;
    logic [15:0] rem_nx;
    logic [15:0] quo_nx;
    logic        wr_en;
    logic        wr_flags;
    logic [2:0]  wr_idx;
    logic [15:0] wr_val;
    logic        stopped;
    logic        br_taken;
    logic [15:0] vec_addr;
    logic [15:0] psr_lo_addr;
    logic        vec_hit;

    assign opc      = inst_reg[15:12];
    assign r1       = inst_reg[11:9];
    assign a        = gr_reg[inst_reg[8:6]];
    assign b        = inst_reg[5] ? {{11{inst_reg[4]}}, inst_reg[4:0]} : gr_reg[inst_reg[2:0]];
    assign npc      = pc_reg + 16'd2;
    assign sext6    = {{10{inst_reg[5]}}, inst_reg[5:0]};
    assign off9x2   = {{6{inst_reg[8]}}, inst_reg[8:0], 1'b0};
    assign off11x2  = {{4{inst_reg[10]}}, inst_reg[10:0], 1'b0};
    assign ldb_addr = a + sext6;
    assign w_addr   = a + {sext6[14:0], 1'b0};
    assign stopped  = halt_reg || fault_reg;
    assign br_taken = (inst_reg[11] && psr_reg[2]) || (inst_reg[10] && psr_reg[1])
                   || (inst_reg[9] && psr_reg[0]);

    // vector byte read in the same cycle as the last push
    assign vec_addr    = {8'h00, item_reg.interrupt_vector};
    assign psr_lo_addr = addr_reg - 16'd3;
    assign vec_hit     = (vec_addr[AW-1:0] == psr_lo_addr[AW-1:0]);

    always_comb begin
        if (inst_reg[4]) begin
            shf_val = a << inst_reg[3:0];
        end else if (inst_reg[5]) begin
            shf_val = 16'($signed(a) >>> inst_reg[3:0]);
        end else begin
            shf_val = a >> inst_reg[3:0];
        end
    end

    assign rem_sh = {div_rem_reg, div_quo_reg[15]};
    assign div_ge = rem_sh >= {1'b0, div_d_reg};
    assign rem_nx = div_ge ? 16'(rem_sh - {1'b0, div_d_reg}) : rem_sh[15:0];
    assign quo_nx = {div_quo_reg[14:0], div_ge};

    assign pop       = (state_reg == S_IDLE) && q_valid;
    assign res_valid = res_vld_reg;
    assign res       = res_reg;

    // memory port and register file write selection
    always_comb begin
        mem_raddr = pc_reg;
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = 8'h00;
        wr_en     = 1'b0;
        wr_flags  = 1'b0;
        wr_idx    = r1;
        wr_val    = 16'h0000;
        case (state_reg)
            S_IDLE: begin
                if (q_valid && q_item.kind == KIND_LOAD) begin
                    mem_we    = 1'b1;
                    mem_waddr = q_item.load_address;
                    mem_wdata = q_item.load_data;
                end
            end
            S_FH: begin
                mem_raddr = pc_reg + 16'd1;
            end
            S_DEC: begin
                case (opc)
                    OP_ADD: begin
                        wr_en = 1'b1; wr_flags = 1'b1; wr_val = a + b;
                    end
                    OP_AND: begin
                        wr_en = 1'b1; wr_flags = 1'b1; wr_val = a & b;
                    end
                    OP_NOT: begin
                        wr_en = 1'b1; wr_flags = 1'b1; wr_val = ~a;
                    end
                    OP_LEA: begin
                        wr_en = 1'b1; wr_flags = 1'b1; wr_val = npc + off9x2;
                    end
                    OP_SHF: begin
                        wr_en = 1'b1; wr_flags = 1'b1; wr_val = shf_val;
                    end
                    OP_JSR: begin
                        wr_en = 1'b1; wr_idx = 3'd7; wr_val = npc;
                    end
                    OP_TRAP: begin
                        wr_en     = 1'b1;
                        wr_idx    = 3'd7;
                        wr_val    = npc + 16'd1;
                        mem_raddr = {7'h00, inst_reg[7:0], 1'b0};
                    end
                    OP_LDB: begin
                        mem_raddr = ldb_addr;
                    end
                    OP_LDR: begin
                        mem_raddr = w_addr;
                    end
                    OP_RTI: begin
                        mem_raddr = gr_reg[6];
                    end
                    OP_STB: begin
                        mem_we    = 1'b1;
                        mem_waddr = ldb_addr;
                        mem_wdata = gr_reg[r1][7:0];
                    end
                    OP_STR: begin
                        mem_we    = !w_addr[0];
                        mem_waddr = w_addr;
                        mem_wdata = gr_reg[r1][15:8];
                    end
                    default: begin
                    end
                endcase
            end
            S_LDB: begin
                wr_en = 1'b1; wr_flags = 1'b1; wr_val = {8'h00, mem_q};
            end
            S_MUL: begin
                wr_en = 1'b1; wr_flags = 1'b1; wr_val = prod_reg;
            end
            S_DIV: begin
                wr_en    = (div_cnt_reg == 4'hF);
                wr_flags = 1'b1;
                wr_val   = inst_reg[5] ? rem_nx : quo_nx;
            end
            S_W1: begin
                mem_raddr = addr_reg + 16'd1;
            end
            S_W2: begin
                if (wt_reg == WT_LDR) begin
                    wr_en = 1'b1; wr_flags = 1'b1; wr_val = {hi_reg, mem_q};
                end else if (wt_reg == WT_RTI_PC) begin
                    mem_raddr = addr_reg + 16'd2;
                end else if (wt_reg == WT_RTI_PSR) begin
                    wr_en = 1'b1; wr_idx = 3'd6; wr_val = addr_reg + 16'd2;
                end
            end
            S_ST2: begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg + 16'd1;
                mem_wdata = st_val_reg[7:0];
            end
            S_I1: begin
                mem_we = 1'b1; mem_waddr = addr_reg - 16'd2; mem_wdata = pc_reg[15:8];
            end
            S_I2: begin
                mem_we = 1'b1; mem_waddr = addr_reg - 16'd1; mem_wdata = pc_reg[7:0];
            end
            S_I3: begin
                mem_we = 1'b1; mem_waddr = addr_reg - 16'd4; mem_wdata = psr_reg[15:8];
            end
            S_I4: begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg - 16'd3;
                mem_wdata = psr_reg[7:0];
                mem_raddr = {8'h00, item_reg.interrupt_vector};
                wr_en     = 1'b1;
                wr_idx    = 3'd6;
                wr_val    = addr_reg - 16'd4;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr[AW-1:0]] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pc_reg      <= 16'h0000;
            psr_reg     <= 16'h0000;
            ssp_reg     <= 16'h0000;
            halt_reg    <= 1'b0;
            fault_reg   <= 1'b0;
            res_vld_reg <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                gr_reg[i] <= 16'h0000;
            end
        end else begin
            if (res_ready) begin
                res_vld_reg <= 1'b0;
            end
            if (wr_en) begin
                gr_reg[wr_idx] <= wr_val;
                wb_vld_reg     <= 1'b1;
                wb_idx_reg     <= wr_idx;
                wb_val_reg     <= wr_val;
                if (wr_flags) begin
                    psr_reg[2:0] <= nzp(wr_val);
                end
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        item_reg    <= q_item;
                        wb_vld_reg  <= 1'b0;
                        wb_idx_reg  <= 3'd0;
                        wb_val_reg  <= 16'h0000;
                        st_vld_reg  <= 1'b0;
                        st_addr_reg <= 16'h0000;
                        st_val_reg  <= 16'h0000;
                        st_word_reg <= 1'b0;
                        state_reg   <= S_DONE;
                        if (q_item.kind == KIND_EXEC && !stopped) begin
                            if (pc_reg[0]) begin
                                fault_reg <= 1'b1;
                            end else begin
                                state_reg <= S_FH;
                            end
                        end else if (q_item.kind == KIND_INTR && !stopped
                                     && {1'b0, psr_reg[9:8]} <= q_item.interrupt_level) begin
                            if (ssp_reg[0]) begin
                                fault_reg <= 1'b1;
                            end else begin
                                psr_reg[15] <= 1'b0;
                                addr_reg    <= ssp_reg;
                                state_reg   <= S_I1;
                            end
                        end
                    end
                end
                S_FH: begin
                    hi_reg    <= mem_q;
                    state_reg <= S_FL;
                end
                S_FL: begin
                    inst_reg  <= {hi_reg, mem_q};
                    state_reg <= S_DEC;
                end
                S_DEC: begin
                    state_reg <= S_DONE;
                    pc_reg    <= npc;
                    case (opc)
                        OP_BR: begin
                            pc_reg <= br_taken ? npc + off9x2 : npc;
                        end
                        OP_JSR: begin
                            pc_reg <= inst_reg[11] ? npc + off11x2 : a;
                        end
                        OP_JMP: begin
                            pc_reg <= a & 16'hFFFE;
                        end
                        OP_LDB: begin
                            state_reg <= S_LDB;
                        end
                        OP_STB: begin
                            st_vld_reg  <= 1'b1;
                            st_addr_reg <= ldb_addr;
                            st_val_reg  <= {8'h00, gr_reg[r1][7:0]};
                        end
                        OP_LDR: begin
                            if (w_addr[0]) begin
                                fault_reg <= 1'b1;
                                pc_reg    <= pc_reg;
                            end else begin
                                addr_reg  <= w_addr;
                                wt_reg    <= WT_LDR;
                                state_reg <= S_W1;
                            end
                        end
                        OP_STR: begin
                            if (w_addr[0]) begin
                                fault_reg <= 1'b1;
                                pc_reg    <= pc_reg;
                            end else begin
                                addr_reg    <= w_addr;
                                st_vld_reg  <= 1'b1;
                                st_addr_reg <= w_addr;
                                st_val_reg  <= gr_reg[r1];
                                st_word_reg <= 1'b1;
                                state_reg   <= S_ST2;
                            end
                        end
                        OP_RTI: begin
                            if (!psr_reg[15]) begin
                                if (gr_reg[6][0]) begin
                                    fault_reg <= 1'b1;
                                    pc_reg    <= pc_reg;
                                end else begin
                                    addr_reg  <= gr_reg[6];
                                    wt_reg    <= WT_RTI_PC;
                                    state_reg <= S_W1;
                                end
                            end
                        end
                        OP_MUL: begin
                            prod_reg  <= 16'(a * b);
                            state_reg <= S_MUL;
                        end
                        OP_DIV: begin
                            div_rem_reg <= 16'h0000;
                            div_quo_reg <= a;
                            div_d_reg   <= gr_reg[inst_reg[2:0]];
                            div_cnt_reg <= 4'h0;
                            state_reg   <= S_DIV;
                        end
                        OP_TRAP: begin
                            addr_reg  <= {7'h00, inst_reg[7:0], 1'b0};
                            wt_reg    <= WT_TRAP;
                            state_reg <= S_W1;
                        end
                        default: begin
                        end
                    endcase
                end
                S_LDB, S_MUL, S_ST2: begin
                    state_reg <= S_DONE;
                end
                S_DIV: begin
                    div_rem_reg <= rem_nx;
                    div_quo_reg <= quo_nx;
                    div_cnt_reg <= div_cnt_reg + 4'h1;
                    if (div_cnt_reg == 4'hF) begin
                        state_reg <= S_DONE;
                    end
                end
                S_W1: begin
                    hi_reg    <= mem_q;
                    state_reg <= S_W2;
                end
                S_W2: begin
                    state_reg <= S_DONE;
                    case (wt_reg)
                        WT_TRAP: begin
                            pc_reg <= {hi_reg, mem_q};
                            if (inst_reg[7:0] == TRAP_HALT) begin
                                halt_reg <= 1'b1;
                            end
                        end
                        WT_RTI_PC: begin
                            tmp_reg   <= {hi_reg, mem_q};
                            addr_reg  <= addr_reg + 16'd2;
                            wt_reg    <= WT_RTI_PSR;
                            state_reg <= S_W1;
                        end
                        WT_RTI_PSR: begin
                            psr_reg <= {hi_reg, mem_q};
                            pc_reg  <= tmp_reg;
                        end
                        default: begin
                        end
                    endcase
                end
                S_I1: state_reg <= S_I2;
                S_I2: state_reg <= S_I3;
                S_I3: state_reg <= S_I4;
                S_I4: state_reg <= S_I5;
                S_I5: begin
                    pc_reg    <= vec_hit ? {8'h00, psr_reg[7:0]} : {8'h00, mem_q};
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!res_vld_reg || res_ready) begin
                        res_vld_reg             <= 1'b1;
                        res_reg.next_pc         <= pc_reg;
                        res_reg.status_word     <= psr_reg;
                        res_reg.writeback_valid <= wb_vld_reg;
                        res_reg.writeback_index <= wb_idx_reg;
                        res_reg.writeback_value <= wb_val_reg;
                        res_reg.store_valid     <= st_vld_reg;
                        res_reg.store_address   <= st_addr_reg;
                        res_reg.store_value     <= st_val_reg;
                        res_reg.store_is_word   <= st_word_reg;
                        res_reg.halted          <= halt_reg;
                        res_reg.fault           <= fault_reg;
                        state_reg               <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_we) begin
                if (cfg_idx == CFG_RESET_PC) begin
                    pc_reg <= cfg_val;
                end else begin
                    ssp_reg <= cfg_val;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/sixteen_bit_cpu_execute_unit.sv @@
// top level of the 16-bit cpu execute unit: front end, request queue, back end
// depends on sbce_pkg, sbce_front, sbce_queue, sbce_back
//
// Each request executes one instruction, raises an interrupt or loads one
// memory byte, and gives exactly one result. The back end reads its memory
// one byte at a time. A load, an unused opcode or a stopped cpu goes straight
// to the result; an instruction takes two fetch reads and a decode, LDR and
// TRAP add a word read, RTI two word reads, DIV computes one quotient bit per
// cycle, LDB, MUL and STR end in a state of their own, and an interrupt does
// four byte pushes and a vector read. The result may wait on m_tready; the
// front end and queue go on accepting requests while the queue has room.
// Memory holds no defined value until written. Configuration writes are
// accepted every cycle and must only come while the unit is idle.
`default_nettype none
module sixteen_bit_cpu_execute_unit
    import sbce_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // load_address, load_data, interrupt_vector, interrupt_level, zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // opcode
    input  wire logic [1:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // next_pc, status_word, writeback_valid, writeback_index, writeback_value,
    // store_valid, store_address, store_value, store_is_word, halted, fault
    output logic [M_TDATA_W-1:0]      m_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);
    logic    push;
    item_t   push_item;
    logic    q_full;
    logic    q_valid;
    item_t   q_item;
    logic    pop;
    result_t res;

    assign cfg_ready = 1'b1;
    assign m_tdata   = res;

    sbce_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    sbce_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

    sbce_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_val   (cfg_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );
endmodule
`default_nettype wire

@@ hw/rtl/sbce_checker.sv @@
// port-level checks of the 16-bit cpu execute unit, bound to the top level
// depends on sbce_pkg
`default_nettype none
module sbce_checker
    import sbce_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);
    logic seen_halt_reg;
    logic seen_fault_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_halt_reg  <= 1'b0;
            seen_fault_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            seen_halt_reg  <= seen_halt_reg || m_tdata[86];
            seen_fault_reg <= seen_fault_reg || m_tdata[87];
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && seen_halt_reg |-> m_tdata[86])
        else $error("halted flag dropped");

    a_fault_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && seen_fault_reg |-> m_tdata[87])
        else $error("fault flag dropped");

    a_wb_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[32] |-> m_tdata[51:33] == 19'h0)
        else $error("writeback fields set without writeback");

    a_st_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[52] |-> m_tdata[85:53] == 33'h0)
        else $error("store fields set without store");
endmodule

bind sixteen_bit_cpu_execute_unit sbce_checker u_sbce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

@@ tb/sixteen_bit_cpu_execute_unit_test.sv @@
// self-checking bench for sixteen_bit_cpu_execute_unit: a shadow cpu predicts every
// result while random programs, interrupts and byte loads stream in under back-pressure
// depends on sbce_pkg and sixteen_bit_cpu_execute_unit
`default_nettype none
module sixteen_bit_cpu_execute_unit_test;
    import sbce_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;

    class cpu_shadow;
        logic [15:0] regs [8];
        logic [15:0] pc, psr, user_sp, boot_pc, sup_sp;
        logic [7:0]  mem [65536];
        bit          loaded [65536];
        bit          halt, fault;
        logic [15:0] missing [$];
        result_t     pending [$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            pc = '0; psr = '0; user_sp = '0; boot_pc = '0; sup_sp = '0;
            halt = 0; fault = 0; errors = 0;
        endfunction

        function logic [15:0] rd8(logic [15:0] a);
            if (!loaded[a]) begin
                missing.push_back(a);
                return 16'h0000;
            end
            return {8'h00, mem[a]};
        endfunction

        function logic [15:0] rd16(logic [15:0] a);
            logic [15:0] hi, lo;
            hi = rd8(a);
            lo = rd8(a + 16'd1);
            return {hi[7:0], lo[7:0]};
        endfunction

        function void wr8(logic [15:0] a, logic [7:0] v, bit commit);
            if (commit) begin
                mem[a] = v;
                loaded[a] = 1;
            end
        endfunction

        function logic [2:0] flags_of(logic [15:0] v);
            if (v == 16'h0000) return 3'b010;
            return v[15] ? 3'b100 : 3'b001;
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
            if (idx == CFG_RESET_PC) begin
                boot_pc = v;
                pc = v;
            end else begin
                sup_sp = v;
            end
        endfunction

        // one request against a copy of the state; commit makes it stick
        function result_t predict_item(logic [1:0] kind, logic [15:0] la, logic [7:0] ld,
                                       logic [7:0] vec, logic [2:0] lvl, bit commit);
            result_t     r;
            logic [15:0] g [8];
            logic [15:0] pcn, ps, usp, inst, npc, a, b, addr, res, wbd, sta, stv;
            logic [2:0]  r1, r2, wbi;
            bit          h, f, abort, wbv, flg, stv_ok, stw;
            r = '0;
            missing.delete();
            g = regs; pcn = pc; ps = psr; usp = user_sp; h = halt; f = fault;
            wbv = 0; flg = 0; wbi = '0; wbd = '0; stv_ok = 0; stw = 0; sta = '0; stv = '0;
            abort = 0;
            if (kind == KIND_LOAD) begin
                wr8(la, ld, commit);
            end else if (kind == KIND_EXEC && !h && !f) begin
                if (pcn[0]) begin
                    abort = 1;
                end else begin
                    inst = rd16(pcn);
                    npc = pcn + 16'd2;
                    r1 = inst[11:9];
                    r2 = inst[8:6];
                    a = g[r2];
                    b = inst[5] ? {{11{inst[4]}}, inst[4:0]} : g[inst[2:0]];
                    case (inst[15:12])
                        OP_BR: begin
                            if ((inst[11] && ps[2]) || (inst[10] && ps[1]) || (inst[9] && ps[0]))
                                npc = npc + {{6{inst[8]}}, inst[8:0], 1'b0};
                        end
                        OP_ADD: begin wbv = 1; flg = 1; wbi = r1; wbd = a + b; end
                        OP_LDB: begin
                            wbv = 1; flg = 1; wbi = r1;
                            wbd = rd8(a + {{10{inst[5]}}, inst[5:0]});
                        end
                        OP_STB: begin
                            stv_ok = 1; sta = a + {{10{inst[5]}}, inst[5:0]};
                            stv = {8'h00, g[r1][7:0]};
                        end
                        OP_JSR: begin
                            res = inst[11] ? npc + {{4{inst[10]}}, inst[10:0], 1'b0} : a;
                            wbv = 1; wbi = 3'd7; wbd = npc;
                            npc = res;
                        end
                        OP_AND: begin wbv = 1; flg = 1; wbi = r1; wbd = a & b; end
                        OP_LDR: begin
                            addr = a + {{9{inst[5]}}, inst[5:0], 1'b0};
                            if (addr[0]) abort = 1;
                            else begin wbv = 1; flg = 1; wbi = r1; wbd = rd16(addr); end
                        end
                        OP_STR: begin
                            addr = a + {{9{inst[5]}}, inst[5:0], 1'b0};
                            if (addr[0]) abort = 1;
                            else begin stv_ok = 1; stw = 1; sta = addr; stv = g[r1]; end
                        end
                        OP_RTI: begin
                            if (!ps[15]) begin
                                addr = g[6];
                                if (addr[0]) abort = 1;
                                else begin
                                    npc = rd16(addr);
                                    ps = rd16(addr + 16'd2);
                                    wbv = 1; wbi = 3'd6; wbd = addr + 16'd4;
                                end
                            end
                        end
                        OP_NOT: begin wbv = 1; flg = 1; wbi = r1; wbd = ~a; end
                        OP_MUL: begin wbv = 1; flg = 1; wbi = r1; wbd = a * b; end
                        OP_DIV: begin
                            b = g[inst[2:0]];
                            if (inst[5]) res = (b != 0) ? a % b : a;
                            else res = (b != 0) ? a / b : 16'hFFFF;
                            wbv = 1; flg = 1; wbi = r1; wbd = res;
                        end
                        OP_JMP: npc = a & 16'hFFFE;
                        OP_SHF: begin
                            if (inst[4]) res = a << inst[3:0];
                            else if (inst[5] && a[15]) res = ~((~a) >> inst[3:0]);
                            else res = a >> inst[3:0];
                            wbv = 1; flg = 1; wbi = r1; wbd = res;
                        end
                        OP_LEA: begin
                            wbv = 1; flg = 1; wbi = r1;
                            wbd = npc + {{6{inst[8]}}, inst[8:0], 1'b0};
                        end
                        default: begin
                            wbv = 1; wbi = 3'd7; wbd = npc + 16'd1;
                            npc = rd16({7'b0, inst[7:0], 1'b0});
                            if (inst[7:0] == TRAP_HALT) h = 1;
                        end
                    endcase
                    if (!abort) begin
                        pcn = npc;
                        if (stv_ok) begin
                            if (stw) begin
                                wr8(sta, stv[15:8], commit);
                                wr8(sta + 16'd1, stv[7:0], commit);
                            end else begin
                                wr8(sta, stv[7:0], commit);
                            end
                        end
                    end
                end
            end else if (kind == KIND_INTR && !h && !f) begin
                if (lvl >= {1'b0, ps[9:8]}) begin
                    if (sup_sp[0]) begin
                        abort = 1;
                    end else begin
                        ps[15] = 1'b0;
                        usp = g[6];
                        wr8(sup_sp - 16'd2, pcn[15:8], commit);
                        wr8(sup_sp - 16'd1, pcn[7:0], commit);
                        wr8(sup_sp - 16'd4, ps[15:8], commit);
                        wr8(sup_sp - 16'd3, ps[7:0], commit);
                        wbv = 1; wbi = 3'd6; wbd = sup_sp - 16'd4;
                        pcn = rd8({8'h00, vec});
                    end
                end
            end
            if (abort) begin
                f = 1;
                wbv = 0; flg = 0; stv_ok = 0;
            end
            if (wbv) begin
                g[wbi] = wbd;
                if (flg) ps[2:0] = flags_of(wbd);
                r.writeback_valid = 1'b1;
                r.writeback_index = wbi;
                r.writeback_value = wbd;
            end
            if (stv_ok) begin
                r.store_valid = 1'b1;
                r.store_address = sta;
                r.store_value = stv;
                r.store_is_word = stw;
            end
            r.next_pc = pcn;
            r.status_word = ps;
            r.halted = h;
            r.fault = f;
            if (commit) begin
                regs = g; pc = pcn; psr = ps; user_sp = usp; halt = h; fault = f;
                pending.push_back(r);
            end
            return r;
        endfunction

        function void compare(string name, logic [15:0] e, logic [15:0] a);
            if (e !== a) begin
                $error("%s expected %h got %h", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (pending.size() == 0) begin
                $error("result with nothing pending: %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            compare("next_pc", e.next_pc, got.next_pc);
            compare("status_word", e.status_word, got.status_word);
            compare("writeback_valid", e.writeback_valid, got.writeback_valid);
            compare("writeback_index", e.writeback_index, got.writeback_index);
            compare("writeback_value", e.writeback_value, got.writeback_value);
            compare("store_valid", e.store_valid, got.store_valid);
            compare("store_address", e.store_address, got.store_address);
            compare("store_value", e.store_value, got.store_value);
            compare("store_is_word", e.store_is_word, got.store_is_word);
            compare("halted", e.halted, got.halted);
            compare("fault", e.fault, got.fault);
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    cpu_shadow cpu;
    int        cycles;
    int        burst_left;
    int        stall_mode;
    int        stall_left;

    sixteen_bit_cpu_execute_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: stall pattern changes between free-running, light and heavy
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) cpu.check_result(result_t'(m_tdata));
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(64, 512);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send(input logic [1:0] kind, input logic [15:0] la, input logic [7:0] ld,
                        input logic [7:0] vec, input logic [2:0] lvl);
        int gap;
        result_t r;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, lvl, vec, ld, la};
        s_tuser <= kind;
        do @(posedge aclk); while (!s_tready);
        r = cpu.predict_item(kind, la, ld, vec, lvl, 1'b1);
    endtask

    task automatic send_load(input logic [15:0] la, input logic [7:0] ld);
        send(KIND_LOAD, la, ld, $urandom_range(0, 255), $urandom_range(0, 7));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (cpu.pending.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cpu.configure(idx, v);
        cfg_valid <= 1'b0;
    endtask

    // place inst at the pc, supply unloaded bytes; strict skips a run that stops the cpu
    task automatic run_inst(input logic [15:0] inst, input bit strict, output bit ran);
        result_t     r;
        logic [15:0] miss [$];
        logic [15:0] at;
        at = cpu.pc;
        send_load(at, inst[15:8]);
        send_load(at + 16'd1, inst[7:0]);
        do begin
            r = cpu.predict_item(KIND_EXEC, '0, '0, '0, '0, 1'b0);
            miss = cpu.missing;
            foreach (miss[i]) send_load(miss[i], $urandom_range(0, 255));
        end while (miss.size() != 0);
        ran = !(strict && (r.fault || r.halted || r.next_pc[0]));
        if (ran) send(KIND_EXEC, $urandom, $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 7));
    endtask

    task automatic raise_irq(input logic [7:0] vec, input logic [2:0] lvl);
        result_t r;
        r = cpu.predict_item(KIND_INTR, '0, '0, vec, lvl, 1'b0);
        if (cpu.missing.size() != 0 || r.next_pc[0])
            send_load({8'h00, vec}, $urandom_range(0, 127) * 2);
        send(KIND_INTR, $urandom, $urandom_range(0, 255), vec, lvl);
    endtask

    task automatic random_inst();
        bit ran;
        ran = 0;
        for (int t = 0; t < 20 && !ran; t++) run_inst($urandom, 1'b1, ran);
        if (!ran) run_inst({OP_ADD, 3'($urandom), 3'($urandom), 1'b1, 5'($urandom)}, 1'b0, ran);
    endtask

    initial begin
        logic [15:0] program_text [$];
        bit          ran;
        int          pick;
        cpu = new();
        cycles = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= KIND_NONE;
        m_tready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_RESET_PC;
        cfg_data <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: each instruction, divide by zero, shift extremes, a trap, interrupt, rti
        program_text = '{16'h5020, 16'h123F, 16'h142F, 16'hB640, 16'hB860, 16'hAA41,
                         16'hD65F, 16'hD66F, 16'hD64F, 16'h9680, 16'hE900, 16'h0E00,
                         16'h0000, 16'h2A00, 16'h32BF, 16'h7202, 16'h6C02, 16'h4802,
                         16'h41C0, 16'hC040};
        send_load(16'h0000, 8'h00);
        send_load(16'hFFFF, 8'hFF);
        foreach (program_text[i]) run_inst(program_text[i], 1'b0, ran);
        send_load(16'h0040, $urandom_range(0, 255));
        send_load(16'h0041, $urandom_range(0, 127) * 2);
        run_inst(16'hF020, 1'b0, ran);
        raise_irq(8'hFF, 3'd0);
        run_inst({OP_RTI, 12'h000}, 1'b0, ran);
        send(KIND_NONE, 16'hFFFF, 8'hFF, 8'hFF, 3'd7);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: write_cfg(CFG_RESET_PC, 16'hFFFE);
                1: write_cfg(CFG_RESET_PC, 16'h0000);
                default: write_cfg(CFG_RESET_PC, $urandom_range(0, 32767) * 2);
            endcase
            case (ph)
                0: write_cfg(CFG_SSP, 16'h0000);
                1: write_cfg(CFG_SSP, 16'hFFFE);
                default: write_cfg(CFG_SSP, $urandom_range(16'h0800, 16'h77FF) * 2);
            endcase
            for (int n = 0; n < 70; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) raise_irq($urandom_range(0, 255), $urandom_range(0, 7));
                else random_inst();
                pick = $urandom_range(0, 99);
                if (pick < 6) send_load($urandom, $urandom_range(0, 255));
                else if (pick < 9) send(KIND_NONE, $urandom, $urandom_range(0, 255),
                                        $urandom_range(0, 255), $urandom_range(0, 7));
            end
        end

        // stop the cpu for good: halt trap, odd fetch or odd stack pointer
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
            send_load(16'h004A, $urandom_range(0, 255));
            send_load(16'h004B, $urandom_range(0, 127) * 2);
            run_inst({OP_TRAP, 4'h0, TRAP_HALT}, 1'b0, ran);
        end else if (pick == 1) begin
            send_load(16'h0011, $urandom_range(0, 127) * 2 + 1);
            send(KIND_INTR, $urandom, $urandom_range(0, 255), 8'h11, 3'd7);
            run_inst(16'h0000, 1'b0, ran);
        end else begin
            drain();
            write_cfg(CFG_SSP, 16'h0001);
            raise_irq(8'h00, 3'd7);
        end
        for (int n = 0; n < 8; n++) begin
            send(2'($urandom_range(0, 3)), $urandom, $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 7));
        end
        drain();

        if (cpu.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
hw/rtl/sbce_pkg.sv
hw/rtl/sbce_front.sv
hw/rtl/sbce_queue.sv
hw/rtl/sbce_back.sv
hw/rtl/sixteen_bit_cpu_execute_unit.sv
hw/rtl/sbce_checker.sv
tb/sixteen_bit_cpu_execute_unit_test.sv
